// File: rtl/ppnc_pkg.sv
`timescale 1ns / 1ps

package ppnc_pkg;

    // Stack geometry. The depth counter must hold STACK_DEPTH itself.
    localparam int STACK_DEPTH = 128;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        FAIL_NONE     = 2'd0,
        FAIL_EMPTY    = 2'd1,
        FAIL_OVERFLOW = 2'd2,
        FAIL_UNCLOSED = 2'd3
    } t_fail;

    // One result item as held in the output and skid registers.
    typedef struct packed {
        logic       number_valid;
        logic       is_close;
        logic [7:0] pair_number;
        logic       verdict_valid;
        logic       matched_ok;
        t_fail      error_kind;
    } t_result;

endpackage

// File: rtl/paren_pair_numbering_checker.sv
`timescale 1ns / 1ps

// Parenthesis pair numbering checker.
// Input stream: one text byte per request on s_tdata, s_tlast marks the last
// byte of a string. Every accepted request yields exactly one result request.
// Output stream: m_tuser carries number_valid and is_close, m_tdata carries
// the pair number, matched_ok and error_kind, and m_tlast is the verdict flag
// that comes back on the result of the last byte of a string.
// A request accepted at an edge has its result written into the output register
// at that edge, or into the skid register when the output register is held.
// Throughput is one request per cycle while the skid register is empty, with at
// most one push or pop on the stack per request; the top of the stack is served
// from a registered memory read plus a bypass register, so back-to-back pops and pushes do not stall.
// When the receiver stalls, the output register holds its result and one more
// result drops into a skid register; s_tready falls only once that skid
// register is occupied, and it depends on no combinational path from m_tready.
// Reset (synchronous, active low) empties the stack, zeroes the pair counter,
// clears the failure code and drops both output registers. Stack memory is not
// cleared: an entry is only read after it was pushed, so no clearing pass runs.
module paren_pair_numbering_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_string
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] pair_number, [8] matched_ok,
                                   // [10:9] error_kind, [15:11] zero
    output logic [1:0]  m_tuser,   // [0] number_valid, [1] is_close
    output logic        m_tlast    // verdict_valid
);

    // Stack control state.
    logic [ppnc_pkg::DEPTH_W-1:0] r_depth, n_depth;
    logic [7:0]                   r_counter, n_counter;
    ppnc_pkg::t_fail              r_fail, n_fail;

    // Stack storage and the registered top-of-stack read.
    logic [7:0] r_stack [ppnc_pkg::STACK_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_bypass;
    logic [7:0] r_push_val;

    // Output register and skid register.
    ppnc_pkg::t_result r_out, r_skid;
    logic              r_out_valid, r_skid_valid;

    logic       in_fire, out_fire;
    logic       is_open, is_closing, active, full, empty;
    logic       do_push, do_pop;
    logic [7:0] top_val, push_num;
    ppnc_pkg::t_fail fail_now;
    logic [ppnc_pkg::DEPTH_W-1:0] depth_after, rd_index;
    logic [ppnc_pkg::STACK_AW-1:0] rd_addr, wr_addr;
    ppnc_pkg::t_result res;

    assign s_tready = !r_skid_valid;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = r_out_valid && m_tready;

    // The top entry was either pushed in the last processed cycle (bypass) or
    // was read from memory at the current top index by the registered read.
    assign top_val = r_bypass ? r_push_val : r_rd_data;

    always_comb begin
        is_open    = (s_tdata == ppnc_pkg::CH_OPEN);
        is_closing = (s_tdata == ppnc_pkg::CH_CLOSE);
        active     = (r_fail == ppnc_pkg::FAIL_NONE);
        full       = (r_depth == ppnc_pkg::DEPTH_W'(ppnc_pkg::STACK_DEPTH));
        empty      = (r_depth == '0);
        do_push    = active && is_open && !full;
        do_pop     = active && is_closing && !empty;
        push_num   = r_counter + 8'd1;

        fail_now = r_fail;
        if (active && is_open && full) begin
            fail_now = ppnc_pkg::FAIL_OVERFLOW;
        end else if (active && is_closing && empty) begin
            fail_now = ppnc_pkg::FAIL_EMPTY;
        end

        if (do_push) begin
            depth_after = r_depth + ppnc_pkg::DEPTH_W'(1);
        end else if (do_pop) begin
            depth_after = r_depth - ppnc_pkg::DEPTH_W'(1);
        end else begin
            depth_after = r_depth;
        end

        res               = '0;
        res.number_valid  = do_push || do_pop;
        res.is_close      = do_pop;
        res.error_kind    = ppnc_pkg::FAIL_NONE;
        if (do_push) begin
            res.pair_number = push_num;
        end else if (do_pop) begin
            res.pair_number = top_val;
        end
        if (s_tlast) begin
            res.verdict_valid = 1'b1;
            if (fail_now != ppnc_pkg::FAIL_NONE) begin
                res.error_kind = fail_now;
            end else if (depth_after != '0) begin
                res.error_kind = ppnc_pkg::FAIL_UNCLOSED;
            end
            res.matched_ok = (res.error_kind == ppnc_pkg::FAIL_NONE);
        end

        // Next state; an end-of-string request clears everything.
        n_depth   = r_depth;
        n_counter = r_counter;
        n_fail    = r_fail;
        if (in_fire) begin
            if (s_tlast) begin
                n_depth   = '0;
                n_counter = 8'd0;
                n_fail    = ppnc_pkg::FAIL_NONE;
            end else begin
                n_depth   = depth_after;
                n_counter = do_push ? push_num : r_counter;
                n_fail    = fail_now;
            end
        end

        // Always read the entry that will be on top after this edge.
        rd_index = n_depth - ppnc_pkg::DEPTH_W'(1);
        rd_addr  = rd_index[ppnc_pkg::STACK_AW-1:0];
        wr_addr  = r_depth[ppnc_pkg::STACK_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && do_push) begin
            r_stack[wr_addr] <= push_num;
        end
        r_rd_data  <= r_stack[rd_addr];
        r_push_val <= push_num;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_counter <= 8'd0;
            r_fail    <= ppnc_pkg::FAIL_NONE;
            r_bypass  <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_counter <= n_counter;
            r_fail    <= n_fail;
            r_bypass  <= in_fire && do_push && !s_tlast;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = {r_out.is_close, r_out.number_valid};
    assign m_tlast  = r_out.verdict_valid;
    assign m_tdata  = {5'd0, r_out.error_kind, r_out.matched_ok, r_out.pair_number};

`ifndef SYNTH
    // The skid register is only filled behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    // The stack never grows past its capacity.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= ppnc_pkg::DEPTH_W'(ppnc_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // An accepted end-of-string request leaves a clean state for the next string.
    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_tlast) |=>
            (r_depth == '0 && r_counter == 8'd0 && r_fail == ppnc_pkg::FAIL_NONE))
        else $error("state not cleared after end of string");

    // A failed string reports no numbers until its end.
    a_no_number_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != ppnc_pkg::FAIL_NONE) |-> !res.number_valid)
        else $error("pair number reported after a failure");
`endif

endmodule

// File: tb/sv/paren_result_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the parenthesis pair numbering checker. Each
// accepted input request runs through a model of the pair stack. The result
// it should give is queued, and every accepted output request is compared
// with the oldest queued result.
module paren_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    input  logic        i_s_tlast,   // end_of_string
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [7:0] pair_number, [8] matched_ok,
                                     // [10:9] error_kind, [15:11] zero
    input  logic [1:0]  i_m_tuser,   // [0] number_valid, [1] is_close
    input  logic        i_m_tlast,   // verdict_valid
    output int          o_error_count,
    output int          o_pending_count
);

    // Model state: pair numbers of the parens that are still open.
    logic [7:0]        open_numbers [ppnc_pkg::STACK_DEPTH];
    int                open_level;
    logic [7:0]        pair_count;
    ppnc_pkg::t_fail   fail_code;

    ppnc_pkg::t_result expected_results [$];

    initial o_error_count = 0;
    initial o_pending_count = 0;

    function automatic ppnc_pkg::t_result predict_paren_result(logic [7:0] ch,
                                                               logic is_last);
        ppnc_pkg::t_result res;
        res = '0;
        // Once a string has failed, its bytes change nothing until the end flag.
        if (fail_code == ppnc_pkg::FAIL_NONE) begin
            if (ch == ppnc_pkg::CH_OPEN) begin
                if (open_level >= ppnc_pkg::STACK_DEPTH) begin
                    fail_code = ppnc_pkg::FAIL_OVERFLOW;
                end else begin
                    pair_count = pair_count + 8'd1;
                    open_numbers[open_level] = pair_count;
                    open_level++;
                    res.number_valid = 1'b1;
                    res.pair_number = pair_count;
                end
            end else if (ch == ppnc_pkg::CH_CLOSE) begin
                if (open_level == 0) begin
                    fail_code = ppnc_pkg::FAIL_EMPTY;
                end else begin
                    open_level--;
                    res.number_valid = 1'b1;
                    res.is_close = 1'b1;
                    res.pair_number = open_numbers[open_level];
                end
            end
        end
        if (is_last) begin
            res.verdict_valid = 1'b1;
            if (fail_code != ppnc_pkg::FAIL_NONE) begin
                res.error_kind = fail_code;
            end else if (open_level != 0) begin
                res.error_kind = ppnc_pkg::FAIL_UNCLOSED;
            end else begin
                res.error_kind = ppnc_pkg::FAIL_NONE;
            end
            res.matched_ok = (res.error_kind == ppnc_pkg::FAIL_NONE);
            open_level = 0;
            pair_count = 8'd0;
            fail_code = ppnc_pkg::FAIL_NONE;
        end
        return res;
    endfunction

    function automatic void compare_field(string field, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_streams
        ppnc_pkg::t_result want;
        ppnc_pkg::t_result got;
        if (!i_rst_n) begin
            open_level = 0;
            pair_count = 8'd0;
            fail_code = ppnc_pkg::FAIL_NONE;
            expected_results.delete();
        end else begin
            // Output side first, so a result never meets the expectation of
            // the request accepted at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got.number_valid  = i_m_tuser[0];
                got.is_close      = i_m_tuser[1];
                got.pair_number   = i_m_tdata[7:0];
                got.matched_ok    = i_m_tdata[8];
                got.error_kind    = ppnc_pkg::t_fail'(i_m_tdata[10:9]);
                got.verdict_valid = i_m_tlast;
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    o_error_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("number_valid", want.number_valid, got.number_valid);
                    compare_field("is_close", want.is_close, got.is_close);
                    compare_field("pair_number", want.pair_number, got.pair_number);
                    compare_field("verdict_valid", want.verdict_valid, got.verdict_valid);
                    compare_field("matched_ok", want.matched_ok, got.matched_ok);
                    compare_field("error_kind", want.error_kind, got.error_kind);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_paren_result(i_s_tdata, i_s_tlast));
            end
        end
        o_pending_count <= expected_results.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the parenthesis pair numbering checker. The checker
// module beside the block predicts and compares; this module only feeds text,
// throttles the result stream and decides pass or fail at the end.
module testbench;

    localparam int RANDOM_ITEMS = 1300;
    // Cycle limit for the whole run, set well above what the slowest correct run needs.
    localparam int CYCLE_LIMIT  = 500000;

    // Shapes of the random strings.
    typedef enum {
        STR_BALANCED,
        STR_DEEP,
        STR_UNCLOSED,
        STR_EXTRA_CLOSE,
        STR_NOISE
    } t_text_style;

    // Patterns of the result receiver.
    typedef enum {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PULSE
    } t_sink_mode;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          error_count;
    int          pending_results;
    int          sent_count  = 0;
    int          burst_left  = 0;
    int          cycle_count = 0;

    paren_pair_numbering_checker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    paren_result_checker result_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_error_count   (error_count),
        .o_pending_count (pending_results)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver switches between patterns at random intervals: always ready,
    // a coin flip, rare acceptance, and a regular pulse.
    // The long always-ready stretches let the block run at full rate.
    always @(posedge i_clk) begin : sink_pattern
        t_sink_mode mode;
        int         mode_left;
        int         pulse_phase;
        if (mode_left <= 0) begin
            mode = t_sink_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        pulse_phase++;
        case (mode)
            SINK_OPEN:   m_tready <= 1'b1;
            SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= pulse_phase[2];
        endcase
    end

    // Offers one byte and returns at the edge where it was accepted. The
    // sender works in bursts; between bursts it usually drops valid for a
    // random gap. Valid is never lowered and raised again in the same step, so a
    // zero-length gap simply leaves it high.
    task automatic send_byte(input logic [7:0] ch, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= is_last;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_repeat(input logic [7:0] ch, input int count);
        repeat (count) send_byte(ch, 1'b0);
    endtask

    // Builds one string in the given style and sends it, with the end flag
    // on its final byte. Well-formed styles keep a running count of open
    // parens so the string reaches deep stack levels before closing out.
    task automatic send_text(input t_text_style style, input int len);
        logic [7:0] text_bytes [$];
        int         open_cnt;
        int         roll;
        int         idx;
        open_cnt = 0;
        for (idx = 0; idx < len; idx++) begin
            roll = $urandom_range(0, 9);
            if (style == STR_NOISE || roll < 2) begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (open_cnt == 0 || roll < ((style == STR_DEEP) ? 7 : 6)) begin
                text_bytes.push_back(ppnc_pkg::CH_OPEN);
                open_cnt++;
            end else begin
                text_bytes.push_back(ppnc_pkg::CH_CLOSE);
                open_cnt--;
            end
        end
        case (style)
            STR_BALANCED, STR_DEEP: begin
                repeat (open_cnt) text_bytes.push_back(ppnc_pkg::CH_CLOSE);
            end
            STR_EXTRA_CLOSE: begin
                // One close too many, then a tail that must be ignored.
                repeat (open_cnt + 1) text_bytes.push_back(ppnc_pkg::CH_CLOSE);
                repeat ($urandom_range(1, 5)) begin
                    roll = $urandom_range(0, 2);
                    text_bytes.push_back(roll == 0 ? ppnc_pkg::CH_OPEN :
                                         roll == 1 ? ppnc_pkg::CH_CLOSE :
                                                     8'($urandom_range(0, 255)));
                end
            end
            STR_UNCLOSED: begin
                if (open_cnt == 0) text_bytes.push_back(ppnc_pkg::CH_OPEN);
            end
            default: ;
        endcase
        for (idx = 0; idx < text_bytes.size(); idx++) begin
            send_byte(text_bytes[idx], idx == text_bytes.size() - 1);
        end
    endtask

    initial begin : stimulus
        int          random_goal;
        int          pick;
        t_text_style style;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A simple matched pair.
        send_byte(ppnc_pkg::CH_OPEN, 1'b0);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b1);
        // A close on an empty stack as the whole string.
        send_byte(ppnc_pkg::CH_CLOSE, 1'b1);
        // An open left standing at the end flag.
        send_byte(ppnc_pkg::CH_OPEN, 1'b1);
        // Byte extremes, no parens at all: balances trivially.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // The first failure sticks; the pair after it is ignored.
        send_byte(ppnc_pkg::CH_CLOSE, 1'b0);
        send_byte(ppnc_pkg::CH_OPEN, 1'b0);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b1);
        // Nesting with a neutral byte inside.
        send_byte(ppnc_pkg::CH_OPEN, 1'b0);
        send_byte(ppnc_pkg::CH_OPEN, 1'b0);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b0);
        send_byte(8'h2A, 1'b0);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b1);
        // A close on empty after a matched pair, then an open that is ignored.
        send_byte(ppnc_pkg::CH_OPEN, 1'b0);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b0);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b0);
        send_byte(ppnc_pkg::CH_OPEN, 1'b1);
        // Fill the stack to the last entry and drain it, then keep opening
        // and closing until the pair counter wraps past 255 to 0.
        send_repeat(ppnc_pkg::CH_OPEN, ppnc_pkg::STACK_DEPTH);
        send_repeat(ppnc_pkg::CH_CLOSE, ppnc_pkg::STACK_DEPTH);
        repeat (140) begin
            send_byte(ppnc_pkg::CH_OPEN, 1'b0);
            send_byte(ppnc_pkg::CH_CLOSE, 1'b0);
        end
        send_byte(8'h80, 1'b1);
        // One open too many overflows; the close after it is ignored.
        send_repeat(ppnc_pkg::CH_OPEN, ppnc_pkg::STACK_DEPTH + 1);
        send_byte(ppnc_pkg::CH_CLOSE, 1'b0);
        send_byte(8'h61, 1'b1);

        // Random strings, mostly well-formed with random content.
        random_goal = sent_count + RANDOM_ITEMS;
        while (sent_count < random_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                style = STR_BALANCED;
            end else if (pick < 58) begin
                style = STR_DEEP;
            end else if (pick < 70) begin
                style = STR_UNCLOSED;
            end else if (pick < 82) begin
                style = STR_EXTRA_CLOSE;
            end else begin
                style = STR_NOISE;
            end
            send_text(style, (style == STR_DEEP) ? $urandom_range(120, 260)
                                                 : $urandom_range(1, 40));
        end
        s_tvalid <= 1'b0;

        // Let the last expectation land, then keep running so that any stray
        // result from the block shows up.
        @(posedge i_clk);
        wait (pending_results == 0);
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && pending_results == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
